/* sv/tactile_grip_force_regulator_top_assert.svh */
// ----------------------------------------------------------------------------
// tactile grip force regulator assertion macros
// concurrent assertion wrappers clocked on clk_i, used by the port checker
// ----------------------------------------------------------------------------
`ifndef TACTILE_GRIP_FORCE_REGULATOR_TOP_ASSERT_SVH
`define TACTILE_GRIP_FORCE_REGULATOR_TOP_ASSERT_SVH

// checked only outside reset
`define TGFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define TGFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* sv/tgfr_pkg.sv */
// ----------------------------------------------------------------------------
// tgfr_pkg
// shared types, codes and constants of the grip force regulator
// ----------------------------------------------------------------------------
package tgfr_pkg;

  localparam int unsigned NUM_TAXELS_DEF = 12;
  localparam int unsigned TAXEL_BITS_DEF = 16;

  localparam int unsigned ACC_W       = 20;
  localparam int unsigned LHS_W       = 27;
  localparam int unsigned LO_W        = 27;
  localparam int unsigned HI_W        = 28;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 23;
  localparam int unsigned S_DATA_W    = 48;
  localparam int unsigned M_DATA_W    = 40;
  localparam int unsigned M_USER_W    = 4;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [ACC_W-1:0] ACC_MAX = '1;
  localparam logic [6:0]       PERCENT = 7'd100;
  localparam logic [7:0]       PRESSURE_MAX = 8'd255;

  // request kinds
  localparam logic [1:0] REQ_DYNAMIC  = 2'd0;
  localparam logic [1:0] REQ_TAXEL    = 2'd1;
  localparam logic [1:0] REQ_POSITION = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_SPEED = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REG_SPEED   = 3'd5;

  // register reset values
  localparam logic [19:0] TARGET_RST      = 20'd0;
  localparam logic [6:0]  BAND_RST        = 7'd35;
  localparam logic [7:0]  STEP_RST        = 8'd1;
  localparam logic [22:0] THRESHOLD_RST   = 23'd8913;
  localparam logic [7:0]  CLOSE_SPEED_RST = 8'd5;
  localparam logic [7:0]  REG_SPEED_RST   = 8'd1;

  // phase codes
  localparam logic [1:0] PHASE_CLOSING  = 2'd0;
  localparam logic [1:0] PHASE_BASELINE = 2'd1;
  localparam logic [1:0] PHASE_REGULATE = 2'd2;
  localparam logic [1:0] PHASE_HOLDING  = 2'd3;

  // force status codes
  localparam logic [1:0] STATUS_NONE      = 2'd0;
  localparam logic [1:0] STATUS_EXCESSIVE = 2'd1;
  localparam logic [1:0] STATUS_WEAK      = 2'd2;
  localparam logic [1:0] STATUS_INBAND    = 2'd3;

  typedef enum logic [1:0] {
    OP_CONTACT,
    OP_TAXEL,
    OP_POSITION
  } op_e;

  typedef struct packed {
    op_e         kind;
    logic [15:0] taxel;
    logic        last;
    logic [7:0]  position;
  } op_t;

  typedef struct packed {
    logic [19:0] target;
    logic [6:0]  band;
    logic [7:0]  step;
    logic [22:0] threshold;
    logic [7:0]  close_speed;
    logic [7:0]  regulate_speed;
  } cfg_t;

  typedef struct packed {
    logic [7:0]       pressure;
    logic [7:0]       speed;
    logic             go;
    logic [1:0]       phase;
    logic [ACC_W-1:0] deviation;
    logic [1:0]       status;
  } res_t;

endpackage

/* sv/tgfr_front.sv */
// ----------------------------------------------------------------------------
// tgfr_front
// accepts stream items, drops idle ones and turns the rest into queue ops
// ----------------------------------------------------------------------------
module tgfr_front (
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [tgfr_pkg::S_DATA_W-1:0] s_axis_tdata,
  input  logic                          s_axis_tlast,
  input  logic [1:0]                    s_axis_tuser,
  input  logic [22:0]                   threshold_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output tgfr_pkg::op_t                 op_o
);
  import tgfr_pkg::*;

  logic signed [23:0] dyn;
  logic [23:0]        mag;
  logic               keep;

  assign dyn = s_axis_tdata[23:0];
  assign mag = dyn[23] ? 24'(-dyn) : 24'(dyn);

  always_comb begin
    keep    = 1'b0;
    op_o    = '0;
    op_o.taxel    = s_axis_tdata[39:24];
    op_o.last     = s_axis_tlast;
    op_o.position = s_axis_tdata[47:40];
    case (s_axis_tuser)
      REQ_DYNAMIC: begin
        keep      = mag > {1'b0, threshold_i};
        op_o.kind = OP_CONTACT;
      end
      REQ_TAXEL: begin
        keep      = 1'b1;
        op_o.kind = OP_TAXEL;
      end
      REQ_POSITION: begin
        keep      = 1'b1;
        op_o.kind = OP_POSITION;
      end
      default: begin
        keep      = 1'b0;
        op_o.kind = OP_POSITION;
      end
    endcase
  end

  assign s_axis_tready = !q_full_i;
  assign push_o        = s_axis_tvalid && !q_full_i && keep;

endmodule

/* sv/tgfr_queue.sv */
// ----------------------------------------------------------------------------
// tgfr_queue
// short op queue between front and back end
// ----------------------------------------------------------------------------
module tgfr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tgfr_pkg::op_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output tgfr_pkg::op_t data_o
);
  import tgfr_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  op_t              mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = count_q == CNT_W'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* sv/tgfr_back.sv */
// ----------------------------------------------------------------------------
// tgfr_back
// grip sequencer: contact stop, baseline capture, force regulation
// ----------------------------------------------------------------------------
module tgfr_back #(
  parameter int unsigned NUM_TAXELS = tgfr_pkg::NUM_TAXELS_DEF,
  parameter int unsigned TAXEL_BITS = tgfr_pkg::TAXEL_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tgfr_pkg::cfg_t cfg_i,
  input  logic           op_valid_i,
  input  tgfr_pkg::op_t  op_i,
  output logic           pop_o,
  input  logic           res_ready_i,
  output logic           res_valid_o,
  output tgfr_pkg::res_t res_o
);
  import tgfr_pkg::*;

  localparam int unsigned IDX_W  = $clog2(NUM_TAXELS + 1);
  localparam int unsigned MEM_AW = (NUM_TAXELS > 1) ? $clog2(NUM_TAXELS) : 1;
  localparam int unsigned SUM_W  = ((TAXEL_BITS > ACC_W) ? TAXEL_BITS : ACC_W) + 1;

  typedef enum logic [1:0] {
    S_CLOSING  = PHASE_CLOSING,
    S_BASELINE = PHASE_BASELINE,
    S_REGULATE = PHASE_REGULATE,
    S_HOLDING  = PHASE_HOLDING
  } phase_e;

  phase_e                phase_q, phase_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [ACC_W-1:0]      acc_q, acc_d;
  logic [7:0]            press_q, press_d;
  logic [7:0]            lastpos_q, lastpos_d;
  logic                  res_valid_q, res_valid_d;
  res_t                  res_q, res_d;

  logic [TAXEL_BITS-1:0] base_q [NUM_TAXELS];
  logic [HI_W-1:0]       hi_q;
  logic [LO_W-1:0]       lo_q;
  logic                  lo_en_q;

  logic                  fire, base_we, in_range;
  logic [TAXEL_BITS-1:0] tv, base_rd, diff;
  logic [SUM_W-1:0]      acc_sum;
  logic [ACC_W-1:0]      acc_sat, frame_sum;
  logic [LHS_W-1:0]      lhs;
  logic                  too_high, too_low;

  assign fire     = op_valid_i && (!res_valid_q || res_ready_i);
  assign pop_o    = fire;
  assign in_range = idx_q < IDX_W'(NUM_TAXELS);
  assign tv       = TAXEL_BITS'(op_i.taxel);
  assign base_rd  = base_q[idx_q[MEM_AW-1:0]];
  assign diff     = (tv >= base_rd) ? tv - base_rd : base_rd - tv;
  assign acc_sum  = SUM_W'(acc_q) + SUM_W'(diff);
  assign acc_sat  = (acc_sum > SUM_W'(ACC_MAX)) ? ACC_MAX : acc_sum[ACC_W-1:0];
  assign frame_sum = in_range ? acc_sat : acc_q;
  assign lhs      = LHS_W'(frame_sum) * LHS_W'(PERCENT);
  assign too_high = {1'b0, lhs} > hi_q;
  assign too_low  = lo_en_q && (lhs < lo_q);

  always_comb begin
    phase_d   = phase_q;
    idx_d     = idx_q;
    acc_d     = acc_q;
    press_d   = press_q;
    lastpos_d = lastpos_q;
    res_d     = res_q;
    base_we   = 1'b0;
    res_valid_d = res_valid_q && !res_ready_i;
    if (fire) begin
      case (op_i.kind)
        OP_POSITION: begin
          lastpos_d = op_i.position;
        end
        OP_CONTACT: begin
          if (phase_q == S_CLOSING) begin
            phase_d         = S_BASELINE;
            idx_d           = '0;
            acc_d           = '0;
            res_valid_d     = 1'b1;
            res_d.pressure  = press_q;
            res_d.speed     = cfg_i.close_speed;
            res_d.go        = 1'b0;
            res_d.phase     = PHASE_BASELINE;
            res_d.deviation = '0;
            res_d.status    = STATUS_NONE;
          end
        end
        OP_TAXEL: begin
          if (phase_q == S_BASELINE || phase_q == S_REGULATE) begin
            if (in_range) begin
              idx_d = idx_q + 1'b1;
              if (phase_q == S_BASELINE) begin
                base_we = 1'b1;
              end else begin
                acc_d = acc_sat;
              end
            end
            if (op_i.last) begin
              idx_d       = '0;
              acc_d       = '0;
              res_valid_d = 1'b1;
              res_d.speed = cfg_i.regulate_speed;
              res_d.go    = 1'b1;
              if (phase_q == S_BASELINE) begin
                phase_d         = S_REGULATE;
                press_d         = lastpos_q;
                res_d.deviation = '0;
                res_d.status    = STATUS_NONE;
              end else begin
                res_d.deviation = frame_sum;
                if (too_high) begin
                  res_d.status = STATUS_EXCESSIVE;
                  if (press_q >= cfg_i.step) begin
                    press_d = press_q - cfg_i.step;
                  end
                end else if (too_low) begin
                  res_d.status = STATUS_WEAK;
                  if ({1'b0, press_q} + {1'b0, cfg_i.step} <= {1'b0, PRESSURE_MAX}) begin
                    press_d = press_q + cfg_i.step;
                  end
                end else begin
                  res_d.status = STATUS_INBAND;
                  phase_d      = S_HOLDING;
                end
              end
              res_d.pressure = press_d;
              res_d.phase    = phase_d;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= S_CLOSING;
      idx_q       <= '0;
      acc_q       <= '0;
      press_q     <= PRESSURE_MAX;
      lastpos_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      idx_q       <= idx_d;
      acc_q       <= acc_d;
      press_q     <= press_d;
      lastpos_q   <= lastpos_d;
      res_valid_q <= res_valid_d;
    end
  end

  // band limits follow the static config registers
  always_ff @(posedge clk_i) begin
    res_q   <= res_d;
    hi_q    <= HI_W'(cfg_i.target) * HI_W'({1'b0, PERCENT} + {1'b0, cfg_i.band});
    lo_q    <= LO_W'(cfg_i.target) * LO_W'(PERCENT - cfg_i.band);
    lo_en_q <= cfg_i.band <= PERCENT;
  end

  always_ff @(posedge clk_i) begin
    if (base_we) begin
      base_q[idx_q[MEM_AW-1:0]] <= tv;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

/* sv/tactile_grip_force_regulator_top.sv */
// Path: a result is presented on the master side once the item that causes it has passed
//   the queue stage, then the registered back end, which a stalled result holds.
// Throughput: one item per cycle unless the queue is full; the back end retires one queued
//   op per cycle unless stalled, with taxel accumulate and band compare in that cycle.
// Reset: asynchronous, active low; control state and config registers return to their
//   defaults at once, no clearing pass; the baseline store is not cleared.
// ----------------------------------------------------------------------------
// tactile_grip_force_regulator_top
// grip sequencer and force regulator: stream front end, op queue, back end
// ----------------------------------------------------------------------------
module tactile_grip_force_regulator_top #(
  parameter int unsigned NUM_TAXELS = tgfr_pkg::NUM_TAXELS_DEF,
  parameter int unsigned TAXEL_BITS = tgfr_pkg::TAXEL_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // dynamic_value[23:0], taxel_value[39:24], position_report[47:40]
  input  logic [tgfr_pkg::S_DATA_W-1:0]   s_axis_tdata,
  input  logic                            s_axis_tlast,
  // req_type[1:0]
  input  logic [1:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // pressure_cmd[7:0], speed_cmd[15:8], go_cmd[16], total_deviation[36:17], zero[39:37]
  output logic [tgfr_pkg::M_DATA_W-1:0]   m_axis_tdata,
  // phase[1:0], force_status[3:2]
  output logic [tgfr_pkg::M_USER_W-1:0]   m_axis_tuser,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tgfr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tgfr_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import tgfr_pkg::*;

  cfg_t cfg_q;
  op_t  front_op, queue_op;
  logic push, q_full, q_valid, pop;
  logic res_valid;
  res_t res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target         <= TARGET_RST;
      cfg_q.band           <= BAND_RST;
      cfg_q.step           <= STEP_RST;
      cfg_q.threshold      <= THRESHOLD_RST;
      cfg_q.close_speed    <= CLOSE_SPEED_RST;
      cfg_q.regulate_speed <= REG_SPEED_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TARGET:      cfg_q.target         <= cfg_data_i[19:0];
        CFG_BAND:        cfg_q.band           <= cfg_data_i[6:0];
        CFG_STEP:        cfg_q.step           <= cfg_data_i[7:0];
        CFG_THRESHOLD:   cfg_q.threshold      <= cfg_data_i[22:0];
        CFG_CLOSE_SPEED: cfg_q.close_speed    <= cfg_data_i[7:0];
        CFG_REG_SPEED:   cfg_q.regulate_speed <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  tgfr_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .threshold_i   (cfg_q.threshold),
    .q_full_i      (q_full),
    .push_o        (push),
    .op_o          (front_op)
  );

  tgfr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_op),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (queue_op)
  );

  tgfr_back #(
    .NUM_TAXELS (NUM_TAXELS),
    .TAXEL_BITS (TAXEL_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .op_valid_i  (q_valid),
    .op_i        (queue_op),
    .pop_o       (pop),
    .res_ready_i (m_axis_tready),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {3'b000, res.deviation, res.go, res.speed, res.pressure};
  assign m_axis_tuser  = {res.status, res.phase};

endmodule

/* sv/tgfr_checker.sv */
// ----------------------------------------------------------------------------
// tgfr_checker
// port level checks of the grip force regulator result stream
// ----------------------------------------------------------------------------
`include "tactile_grip_force_regulator_top_assert.svh"

module tgfr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [tgfr_pkg::M_DATA_W-1:0] m_axis_tdata,
  input logic [tgfr_pkg::M_USER_W-1:0] m_axis_tuser
);
  import tgfr_pkg::*;

  logic       go;
  logic [1:0] phase;
  logic [1:0] status;

  assign go     = m_axis_tdata[16];
  assign phase  = m_axis_tuser[1:0];
  assign status = m_axis_tuser[3:2];

  // stalled result holds
  `TGFR_ASSERT(a_stall_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  // stop command only on contact
  `TGFR_ASSERT_ALWAYS(a_stop_contact, m_axis_tvalid && !go |-> phase == PHASE_BASELINE && status == STATUS_NONE, "stop outside contact")

  // in band ends regulation
  `TGFR_ASSERT_ALWAYS(a_inband_hold, m_axis_tvalid && status == STATUS_INBAND |-> phase == PHASE_HOLDING && go, "in band without holding")

  // pressure steps only while regulating
  `TGFR_ASSERT_ALWAYS(a_step_phase, m_axis_tvalid && (status == STATUS_EXCESSIVE || status == STATUS_WEAK) |-> phase == PHASE_REGULATE && go, "step outside regulation")

  // holding is terminal
  `TGFR_ASSERT(a_hold_final, m_axis_tvalid && m_axis_tready && status == STATUS_INBAND |=> !m_axis_tvalid, "result after holding")

endmodule

bind tactile_grip_force_regulator_top tgfr_checker u_tgfr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grip force regulator testbench
// directed closing, contact and baseline script, then randomized regulation
// phases under changing settings; every command is checked against fixed
// script values or an in-bench grip model, with random bursts and output stalls
// ----------------------------------------------------------------------------
module testbench;
  import tgfr_pkg::*;

  localparam int NTAX        = NUM_TAXELS_DEF;
  localparam int SCRIPT_LEN  = 23;
  localparam int PHASE_CNT   = 10;
  localparam int PHASE_ITEMS = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 200000;
  localparam longint SUM_MAX = 64'hfffff;

  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  req;
    logic [23:0] dyn;
    logic [15:0] taxel;
    logic        last;
    logic [7:0]  pos;
  } grip_item_t;

  typedef struct packed {
    grip_item_t item;
    logic       fixed;
    res_t       want;
  } grip_row_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE,
    READY_MOSTLY
  } ready_mode_e;

  localparam grip_row_t SCRIPT [SCRIPT_LEN] = '{
    // closing: positive limit is not above the top threshold
    '{'{REQ_DYNAMIC,  24'h7fffff, 16'h0000, 1'b0, 8'h00}, 1'b0, '0},
    '{'{REQ_DYNAMIC,  24'h000000, 16'h0000, 1'b0, 8'h00}, 1'b0, '0},
    '{'{REQ_POSITION, 24'h000000, 16'h0000, 1'b0, 8'hff}, 1'b0, '0},
    // taxels and unused kinds are dropped while closing
    '{'{REQ_TAXEL,    24'h000000, 16'hffff, 1'b1, 8'h00}, 1'b0, '0},
    '{'{REQ_UNUSED,   24'hffffff, 16'hffff, 1'b1, 8'hff}, 1'b0, '0},
    '{'{REQ_POSITION, 24'hffffff, 16'hffff, 1'b1, 8'h00}, 1'b0, '0},
    // most negative sample always makes contact
    '{'{REQ_DYNAMIC,  24'h800000, 16'h0000, 1'b0, 8'h00}, 1'b1,
      '{8'd255, 8'd255, 1'b0, PHASE_BASELINE, 20'd0, STATUS_NONE}},
    '{'{REQ_DYNAMIC,  24'h800000, 16'h0000, 1'b0, 8'h00}, 1'b0, '0},
    '{'{REQ_POSITION, 24'h000000, 16'h0000, 1'b0, 8'd253}, 1'b0, '0},
    // baseline frame
    '{'{REQ_TAXEL,    24'h000000, 16'd0,     1'b0, 8'h00}, 1'b0, '0},
    '{'{REQ_TAXEL,    24'h000000, 16'd65535, 1'b0, 8'h00}, 1'b0, '0},
    '{'{REQ_TAXEL,    24'h000000, 16'd1,     1'b0, 8'h00}, 1'b0, '0},
    '{'{REQ_TAXEL,    24'h000000, 16'd32768, 1'b0, 8'h00}, 1'b0, '0},
    '{'{REQ_TAXEL,    24'h000000, 16'd100,   1'b0, 8'h00}, 1'b0, '0},
    '{'{REQ_TAXEL,    24'h000000, 16'd40000, 1'b0, 8'h00}, 1'b0, '0},
    '{'{REQ_TAXEL,    24'h000000, 16'd7,     1'b0, 8'h00}, 1'b0, '0},
    '{'{REQ_TAXEL,    24'h000000, 16'd65534, 1'b0, 8'h00}, 1'b0, '0},
    '{'{REQ_TAXEL,    24'h000000, 16'd12345, 1'b0, 8'h00}, 1'b0, '0},
    '{'{REQ_TAXEL,    24'h000000, 16'd500,   1'b0, 8'h00}, 1'b0, '0},
    '{'{REQ_TAXEL,    24'h000000, 16'd30000, 1'b0, 8'h00}, 1'b0, '0},
    '{'{REQ_TAXEL,    24'h000000, 16'd2000,  1'b0, 8'h00}, 1'b0, '0},
    // taxels past the frame size are dropped, frame still ends on last
    '{'{REQ_TAXEL,    24'h000000, 16'hffff,  1'b0, 8'h00}, 1'b0, '0},
    '{'{REQ_TAXEL,    24'h000000, 16'h0000,  1'b1, 8'h00}, 1'b1,
      '{8'd253, 8'd0, 1'b1, PHASE_REGULATE, 20'd0, STATUS_NONE}}
  };

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
  logic                  s_axis_tlast  = 1'b0;
  logic [1:0]            s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_axis_tdata;
  logic [M_USER_W-1:0]   m_axis_tuser;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  // grip model state
  cfg_t        grip_cfg = '{TARGET_RST, BAND_RST, STEP_RST, THRESHOLD_RST,
                            CLOSE_SPEED_RST, REG_SPEED_RST};
  logic [1:0]  grip_phase    = PHASE_CLOSING;
  logic [15:0] base_taxel [NTAX];
  int          tax_idx       = 0;
  longint      dev_sum       = 0;
  logic [7:0]  grip_pressure = 8'd255;
  logic [7:0]  last_pos      = 8'd0;

  res_t        grip_cmd_q [$];
  int          mismatch_cnt  = 0;
  int          checked_cnt   = 0;
  int          items_sent    = 0;
  int          counted_items = 0;
  int          status_hits [4] = '{0, 0, 0, 0};
  int          cycle_cnt     = 0;
  int          burst_left    = 0;
  int          gap_max       = 0;
  logic        hold_req      = 1'b0;
  logic        hold_done     = 1'b0;
  int          hold_left     = 0;
  int          mode_left     = 0;
  ready_mode_e stall_mode    = READY_ALWAYS;

  tactile_grip_force_regulator_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // next command of the grip sequencer for one accepted item, if any
  function automatic logic next_grip_cmd(input grip_item_t it, output res_t cmd);
    longint     level;
    longint     lhs;
    longint     hi;
    longint     lo;
    logic [15:0] diff;
    logic [1:0]  status;
    cmd = '0;
    case (it.req)
      REQ_POSITION: last_pos = it.pos;
      REQ_DYNAMIC: begin
        if (grip_phase == PHASE_CLOSING) begin
          level = longint'($signed(it.dyn));
          if (level < 0) level = -level;
          if (level > longint'(grip_cfg.threshold)) begin
            grip_phase = PHASE_BASELINE;
            tax_idx = 0;
            dev_sum = 0;
            cmd = '{grip_pressure, grip_cfg.close_speed, 1'b0, PHASE_BASELINE, '0,
                    STATUS_NONE};
            return 1'b1;
          end
        end
      end
      REQ_TAXEL: begin
        if (grip_phase == PHASE_BASELINE || grip_phase == PHASE_REGULATE) begin
          if (tax_idx < NTAX) begin
            if (grip_phase == PHASE_BASELINE) begin
              base_taxel[tax_idx] = it.taxel;
            end else begin
              diff = (it.taxel >= base_taxel[tax_idx]) ? it.taxel - base_taxel[tax_idx]
                                                       : base_taxel[tax_idx] - it.taxel;
              dev_sum = dev_sum + longint'(diff);
              if (dev_sum > SUM_MAX) dev_sum = SUM_MAX;
            end
            tax_idx++;
          end
          if (it.last) begin
            tax_idx = 0;
            if (grip_phase == PHASE_BASELINE) begin
              grip_phase = PHASE_REGULATE;
              dev_sum = 0;
              grip_pressure = last_pos;
              cmd = '{grip_pressure, grip_cfg.regulate_speed, 1'b1, PHASE_REGULATE, '0,
                      STATUS_NONE};
              return 1'b1;
            end
            lhs = dev_sum * 100;
            hi = longint'(grip_cfg.target) * (100 + longint'(grip_cfg.band));
            lo = longint'(grip_cfg.target) * (100 - longint'(grip_cfg.band));
            if (lhs > hi) begin
              status = STATUS_EXCESSIVE;
              if (grip_pressure >= grip_cfg.step) grip_pressure = grip_pressure - grip_cfg.step;
            end else if (lhs < lo) begin
              status = STATUS_WEAK;
              if (int'(grip_pressure) + int'(grip_cfg.step) <= 255) begin
                grip_pressure = grip_pressure + grip_cfg.step;
              end
            end else begin
              status = STATUS_INBAND;
              grip_phase = PHASE_HOLDING;
            end
            cmd = '{grip_pressure, grip_cfg.regulate_speed, 1'b1, grip_phase, 20'(dev_sum),
                    status};
            dev_sum = 0;
            return 1'b1;
          end
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] result %0d %s: got %0d, want %0d", $time, checked_cnt, what, got, want);
    mismatch_cnt++;
  endtask

  task automatic check_cmd();
    res_t got;
    res_t want;
    got.pressure  = m_axis_tdata[7:0];
    got.speed     = m_axis_tdata[15:8];
    got.go        = m_axis_tdata[16];
    got.deviation = m_axis_tdata[36:17];
    got.phase     = m_axis_tuser[1:0];
    got.status    = m_axis_tuser[3:2];
    if (grip_cmd_q.size() == 0) begin
      report_mismatch("unexpected transfer, tdata", longint'(m_axis_tdata), 0);
      return;
    end
    want = grip_cmd_q.pop_front();
    if (got.pressure !== want.pressure)
      report_mismatch("pressure_cmd", got.pressure, want.pressure);
    if (got.speed !== want.speed)
      report_mismatch("speed_cmd", got.speed, want.speed);
    if (got.go !== want.go)
      report_mismatch("go_cmd", got.go, want.go);
    if (got.phase !== want.phase)
      report_mismatch("phase", got.phase, want.phase);
    if (got.deviation !== want.deviation)
      report_mismatch("total_deviation", got.deviation, want.deviation);
    if (got.status !== want.status)
      report_mismatch("force_status", got.status, want.status);
    if (m_axis_tdata[39:37] !== 3'b000)
      report_mismatch("tdata padding", m_axis_tdata[39:37], 0);
    status_hits[want.status]++;
    checked_cnt++;
  endtask

  // output side: own stall pattern plus one long hold-off on request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) check_cmd();
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        stall_mode = ready_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(8, 80);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (stall_mode)
          READY_ALWAYS: m_axis_tready <= 1'b1;
          READY_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
          READY_SPARSE: m_axis_tready <= (cycle_cnt % 4 == 0);
          default:      m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d commands pending", cycle_cnt, grip_cmd_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_item(input grip_item_t it, input logic fixed, input res_t want);
    int   gap;
    res_t cmd;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0 || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, gap_max);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {it.pos, it.taxel, it.dyn};
    s_axis_tlast  <= it.last;
    s_axis_tuser  <= it.req;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
    if (it.req == REQ_TAXEL || it.req == REQ_POSITION) counted_items++;
    if (next_grip_cmd(it, cmd) && !fixed) grip_cmd_q.push_back(cmd);
    if (fixed) grip_cmd_q.push_back(want);
  endtask

  task automatic send_noise();
    grip_item_t it;
    case ($urandom_range(0, 2))
      0:       it.req = REQ_DYNAMIC;
      1:       it.req = REQ_POSITION;
      default: it.req = REQ_UNUSED;
    endcase
    it.dyn   = 24'($urandom);
    it.taxel = 16'($urandom);
    it.last  = 1'($urandom);
    it.pos   = 8'($urandom);
    send_item(it, 1'b0, '0);
  endtask

  task automatic send_frame(input int len);
    grip_item_t it;
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 6) == 0) send_noise();
      it.req  = REQ_TAXEL;
      it.dyn  = 24'($urandom);
      it.pos  = 8'($urandom);
      it.last = (k == len - 1);
      case ($urandom_range(0, 19))
        0:       it.taxel = 16'h0000;
        1:       it.taxel = 16'hffff;
        // zero deviation on this element
        2:       it.taxel = (k > 0 && k < NTAX) ? base_taxel[k] : 16'($urandom);
        default: it.taxel = 16'($urandom);
      endcase
      send_item(it, 1'b0, '0);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic write_settings(input cfg_t c);
    write_reg(CFG_TARGET,      CFG_DATA_W'(c.target));
    write_reg(CFG_BAND,        CFG_DATA_W'(c.band));
    write_reg(CFG_STEP,        CFG_DATA_W'(c.step));
    write_reg(CFG_THRESHOLD,   c.threshold);
    write_reg(CFG_CLOSE_SPEED, CFG_DATA_W'(c.close_speed));
    write_reg(CFG_REG_SPEED,   CFG_DATA_W'(c.regulate_speed));
    cfg_valid_i <= 1'b0;
    grip_cfg = c;
  endtask

  task automatic drain_commands();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (grip_cmd_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_step();
    case ($urandom_range(0, 3))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    cfg_t settings;
    int   phase_start;
    int   len;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    settings = '{20'hfffff, 7'd0, 8'd1, 23'h7fffff, 8'd255, 8'd0};
    write_settings(settings);
    foreach (SCRIPT[i]) send_item(SCRIPT[i].item, SCRIPT[i].fixed, SCRIPT[i].want);

    for (int p = 0; p < PHASE_CNT; p++) begin
      drain_commands();
      settings = grip_cfg;
      settings.regulate_speed = 8'($urandom);
      settings.threshold      = 23'($urandom);
      settings.close_speed    = 8'($urandom);
      case (p)
        // weak with unit step walks pressure into the upper limit
        0: settings.regulate_speed = 8'd255;
        // full step from the top lands on zero, then holds there
        1: begin
          settings.target = '0;
          settings.band   = 7'($urandom_range(0, 100));
          settings.step   = 8'd255;
        end
        2: settings.step = 8'd1;
        3, 5: begin
          settings.target = '1;
          settings.band   = 7'($urandom_range(0, 20));
          settings.step   = (p == 5) ? 8'd0 : pick_step();
        end
        4, 6: begin
          settings.target = '0;
          settings.band   = 7'($urandom_range(0, 100));
          settings.step   = pick_step();
        end
        // band above 100 makes the low bound negative, weak never fires
        7: begin
          settings.target = 20'($urandom_range(0, 2000));
          settings.band   = 7'($urandom_range(101, 127));
          settings.step   = pick_step();
        end
        8: begin
          settings.target = 20'($urandom_range(100000, 400000));
          settings.band   = 7'($urandom_range(0, 100));
          settings.step   = pick_step();
        end
        // full band: first frame is in band, then holding
        default: begin
          settings.target = '1;
          settings.band   = 7'd100;
        end
      endcase
      if (p == 3) begin
        settings.threshold   = '0;
        settings.close_speed = '0;
      end
      write_settings(settings);
      gap_max = (p == 0 || p == 3) ? 0 : 8;
      if (p == 4) hold_req <= 1'b1;
      phase_start = counted_items;
      while (counted_items - phase_start < PHASE_ITEMS) begin
        case ($urandom_range(0, 9))
          0:       len = $urandom_range(1, NTAX - 1);
          1:       len = $urandom_range(NTAX + 1, 16);
          default: len = NTAX;
        endcase
        send_frame(len);
      end
    end
    drain_commands();
    repeat (8) @(posedge clk_i);

    $display("covered contact, baseline and %0d setting phases: %0d items, %0d commands checked",
             PHASE_CNT, items_sent, checked_cnt);
    $display("status mix excessive %0d, weak %0d, in band %0d; final phase %0d, %0d mismatches",
             status_hits[STATUS_EXCESSIVE], status_hits[STATUS_WEAK],
             status_hits[STATUS_INBAND], grip_phase, mismatch_cnt);
    if (mismatch_cnt == 0 && grip_cmd_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
